FILE: hw/rtl/byte_counted_descriptor_queue_macros.svh
// ----------------------------------------------------------------------------
// byte counted descriptor queue assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BYTE_COUNTED_DESCRIPTOR_QUEUE_MACROS_SVH
`define BYTE_COUNTED_DESCRIPTOR_QUEUE_MACROS_SVH

// same-cycle implication
`define BCDQ_AST_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define BCDQ_AST_NXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: hw/rtl/bcdq_pkg.sv
// ----------------------------------------------------------------------------
// bcdq_pkg
// shared constants, types and helpers of the byte counted descriptor queue
// ----------------------------------------------------------------------------
package bcdq_pkg;

	// ring geometry
	localparam int RING_DEPTH = 16;
	localparam int LEN_BITS   = 16;

	// port field widths
	localparam int ADDR_W  = 32;
	localparam int FLEN_W  = 16;
	localparam int AMT_W   = 20;
	localparam int TOT_W   = 20;
	localparam int DRN_W   = 32;

	// derived widths
	localparam int PTR_W   = $clog2(RING_DEPTH);
	localparam int CNT_W   = $clog2(RING_DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int MOVED_W = ((LEN_BITS > AMT_W) ? LEN_BITS : AMT_W) + 1;

	localparam logic [CNT_W-1:0] RING_FULL = CNT_W'(RING_DEPTH);

	// command codes
	localparam logic [1:0] CMD_ENQ   = 2'd0;
	localparam logic [1:0] CMD_MOVE  = 2'd1;
	localparam logic [1:0] CMD_TRIM  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// ring select codes
	localparam logic SEL_QUEUED  = 1'b0;
	localparam logic SEL_PENDING = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [LEN_BITS-1:0] len;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [PTR_W-1:0] head;
		logic [CNT_W-1:0] count;
		logic [TOT_W-1:0] unread;
		logic [DRN_W-1:0] drained;
	} ring_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic              queue_sel;
		logic [ADDR_W-1:0] entry_addr;
		logic [FLEN_W-1:0] entry_len;
		logic [AMT_W-1:0]  amount;
		logic              drain_flag;
	} req_t;

	typedef struct packed {
		logic [TOT_W-1:0]  bytes_done;
		logic              status;
		logic [TOT_W-1:0]  queued_unread;
		logic [TOT_W-1:0]  pending_unread;
		logic [DRN_W-1:0]  queued_drained;
		logic [DRN_W-1:0]  pending_drained;
		logic [ADDR_W-1:0] head_addr;
		logic [FLEN_W-1:0] head_len;
	} res_t;

	// ring slot at head plus offset, offset never above the depth
	function automatic logic [PTR_W-1:0] slot_add(logic [PTR_W-1:0] head,
		logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(head) + SUM_W'(off);
		if (s >= SUM_W'(RING_DEPTH)) begin
			s = s - SUM_W'(RING_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	// port length to stored length
	function automatic logic [LEN_BITS-1:0] len_in(logic [FLEN_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[LEN_BITS-1:0];
	endfunction

	// stored length to port length
	function automatic logic [FLEN_W-1:0] len_out(logic [LEN_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[FLEN_W-1:0];
	endfunction

	// stored length folded into a 20-bit total
	function automatic logic [TOT_W-1:0] len_tot(logic [LEN_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[TOT_W-1:0];
	endfunction

	// 32-bit value cut to a stored length
	function automatic logic [LEN_BITS-1:0] to_len(logic [31:0] v);
		return v[LEN_BITS-1:0];
	endfunction

endpackage

FILE: hw/rtl/bcdq_ram.sv
// ----------------------------------------------------------------------------
// bcdq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bcdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/bcdq_engine.sv
// ----------------------------------------------------------------------------
// bcdq_engine
// command sequencer: ring pointers and totals, walks ring entries through
// the two descriptor rams one entry per cycle
// ----------------------------------------------------------------------------
`include "byte_counted_descriptor_queue_macros.svh"

module bcdq_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  bcdq_pkg::req_t    req,
	output logic              busy,
	input  bcdq_pkg::entry_t  q_rdata,
	input  bcdq_pkg::entry_t  p_rdata,
	output bcdq_pkg::ram_req_t q_req,
	output bcdq_pkg::ram_req_t p_req,
	input  logic              res_free,
	output logic              res_valid,
	output bcdq_pkg::res_t    res
);
	import bcdq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_MOVE = 3'd2;
	localparam logic [2:0] S_TRIM = 3'd3;
	localparam logic [2:0] S_HEAD = 3'd4;
	localparam logic [2:0] S_RES  = 3'd5;

	logic [2:0]          state_q, state_d;
	ring_t               qr_q, qr_d, pr_q, pr_d;

	// latched request
	logic [1:0]          cmd_q;
	logic                sel_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [LEN_BITS-1:0] len_q;
	logic [AMT_W-1:0]    amount_q;
	logic                drain_q;

	// working registers
	logic [AMT_W-1:0]    left_q, left_d;
	logic [TOT_W-1:0]    done_q, done_d;
	logic [MOVED_W-1:0]  moved_q, moved_d;
	logic                status_q, status_d;

	logic                accept;
	ring_t               tr, tr_n;
	logic                tr_upd;
	ram_req_t            t_req;
	entry_t              ent;
	entry_t              t_rdata;
	logic [MOVED_W-1:0]  moved_n;
	logic [AMT_W-1:0]    left_n;

	assign busy    = (state_q != S_IDLE);
	assign accept  = req_valid && !busy;
	assign tr      = (sel_q == SEL_PENDING) ? pr_q : qr_q;
	assign t_rdata = (sel_q == SEL_PENDING) ? p_rdata : q_rdata;

	// next state and ram requests
	always_comb begin
		state_d   = state_q;
		qr_d      = qr_q;
		pr_d      = pr_q;
		left_d    = left_q;
		done_d    = done_q;
		moved_d   = moved_q;
		status_d  = status_q;
		tr_n      = tr;
		tr_upd    = 1'b0;
		t_req     = '0;
		q_req     = '0;
		p_req     = '0;
		ent       = '0;
		moved_n   = moved_q;
		left_n    = left_q;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d  = S_EXEC;
					left_d   = req.amount;
					done_d   = '0;
					moved_d  = '0;
					status_d = 1'b0;
				end
			end
			S_EXEC: begin
				state_d = S_HEAD;
				unique case (cmd_q)
					CMD_ENQ: begin
						if (qr_q.count == RING_FULL) begin
							status_d = 1'b1;
						end else begin
							q_req.we    = 1'b1;
							q_req.waddr = slot_add(qr_q.head, qr_q.count);
							q_req.wdata = '{addr: addr_q, len: len_q};
							qr_d.count  = qr_q.count + CNT_W'(1);
							qr_d.unread = qr_q.unread + len_tot(len_q);
						end
					end
					CMD_MOVE: begin
						if (qr_q.count != '0 && amount_q != '0 &&
							pr_q.count != RING_FULL) begin
							q_req.re    = 1'b1;
							q_req.raddr = qr_q.head;
							state_d     = S_MOVE;
						end
					end
					CMD_TRIM: begin
						tr_upd = 1'b1;
						if (drain_q) begin
							tr_n.drained = tr.drained + DRN_W'(amount_q);
						end
						if (left_q != '0 && tr.count != '0) begin
							t_req.re    = 1'b1;
							t_req.raddr = tr.head;
							state_d     = S_TRIM;
						end
					end
					CMD_CLEAR: begin
						// unread always equals the sum of the entry lengths
						tr_upd      = 1'b1;
						done_d      = tr.unread;
						tr_n.head   = slot_add(tr.head, tr.count);
						tr_n.count  = '0;
						tr_n.unread = '0;
					end
					default: begin
						state_d = S_HEAD;
					end
				endcase
			end
			S_MOVE: begin
				// relink the queued head to the pending tail
				ent          = q_rdata;
				p_req.we     = 1'b1;
				p_req.waddr  = slot_add(pr_q.head, pr_q.count);
				p_req.wdata  = ent;
				pr_d.count   = pr_q.count + CNT_W'(1);
				pr_d.unread  = pr_q.unread + len_tot(ent.len);
				qr_d.unread  = qr_q.unread - len_tot(ent.len);
				qr_d.drained = qr_q.drained + DRN_W'(ent.len);
				qr_d.head    = slot_add(qr_q.head, CNT_W'(1));
				qr_d.count   = qr_q.count - CNT_W'(1);
				moved_n      = moved_q + MOVED_W'(ent.len);
				moved_d      = moved_n;
				done_d       = moved_n[TOT_W-1:0];
				if (qr_d.count != '0 && moved_n < MOVED_W'(amount_q) &&
					pr_d.count != RING_FULL) begin
					q_req.re    = 1'b1;
					q_req.raddr = qr_d.head;
				end else begin
					state_d = S_HEAD;
				end
			end
			S_TRIM: begin
				ent    = t_rdata;
				tr_upd = 1'b1;
				if (32'(ent.len) <= 32'(left_q)) begin
					// whole head entry dropped
					left_n      = left_q - len_tot(ent.len);
					left_d      = left_n;
					done_d      = done_q + len_tot(ent.len);
					tr_n.unread = tr.unread - len_tot(ent.len);
					tr_n.head   = slot_add(tr.head, CNT_W'(1));
					tr_n.count  = tr.count - CNT_W'(1);
					if (left_n != '0 && tr_n.count != '0) begin
						t_req.re    = 1'b1;
						t_req.raddr = tr_n.head;
					end else begin
						state_d = S_HEAD;
					end
				end else begin
					// head partly consumed, write back the shrunk entry
					t_req.we         = 1'b1;
					t_req.waddr      = tr.head;
					t_req.wdata.addr = ent.addr + ADDR_W'(left_q);
					t_req.wdata.len  = to_len(32'(ent.len) - 32'(left_q));
					tr_n.unread      = tr.unread - left_q;
					done_d           = done_q + left_q;
					left_d           = '0;
					state_d          = S_HEAD;
				end
			end
			S_HEAD: begin
				// the last ring write lands before this read is issued, so this read sees it
				p_req.re    = 1'b1;
				p_req.raddr = pr_q.head;
				state_d     = S_RES;
			end
			S_RES: begin
				if (res_free) begin
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// route target ring updates and ram accesses
		if (tr_upd) begin
			if (sel_q == SEL_PENDING) begin
				pr_d = tr_n;
			end else begin
				qr_d = tr_n;
			end
		end
		if (t_req.we || t_req.re) begin
			if (sel_q == SEL_PENDING) begin
				p_req = t_req;
			end else begin
				q_req = t_req;
			end
		end
	end

	// result assembly
	always_comb begin
		res.bytes_done      = done_q;
		res.status          = status_q;
		res.queued_unread   = qr_q.unread;
		res.pending_unread  = pr_q.unread;
		res.queued_drained  = qr_q.drained;
		res.pending_drained = pr_q.drained;
		if (pr_q.count != '0) begin
			res.head_addr = p_rdata.addr;
			res.head_len  = len_out(p_rdata.len);
		end else begin
			res.head_addr = '0;
			res.head_len  = '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			qr_q    <= '0;
			pr_q    <= '0;
		end else begin
			state_q <= state_d;
			qr_q    <= qr_d;
			pr_q    <= pr_d;
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.cmd;
			sel_q    <= req.queue_sel;
			addr_q   <= req.entry_addr;
			len_q    <= len_in(req.entry_len);
			amount_q <= req.amount;
			drain_q  <= req.drain_flag;
		end
		left_q   <= left_d;
		done_q   <= done_d;
		moved_q  <= moved_d;
		status_q <= status_d;
	end

	`BCDQ_AST_NXT(a_accept_exec, accept, state_q == S_EXEC, "accepted request did not start")
	`BCDQ_AST_IMP(a_move_room, state_q == S_MOVE, qr_q.count != '0 && pr_q.count != RING_FULL, "move step without source entry or room")
	`BCDQ_AST_IMP(a_trim_live, state_q == S_TRIM, left_q != '0 && tr.count != '0, "trim step on empty ring or zero remainder")
	`BCDQ_AST_NXT(a_move_keep, state_q == S_MOVE, SUM_W'(qr_q.count) + SUM_W'(pr_q.count) == $past(SUM_W'(qr_q.count) + SUM_W'(pr_q.count)), "move lost or duplicated an entry")
	`BCDQ_AST_NXT(a_clear_empty, state_q == S_EXEC && cmd_q == CMD_CLEAR, tr.count == '0 && tr.unread == '0, "clear left entries behind")

endmodule

FILE: hw/rtl/byte_counted_descriptor_queue.sv
// ----------------------------------------------------------------------------
// byte_counted_descriptor_queue
// enqueue and clear go from the exec state via the head read and result
// states to the output register; move and trim first walk the ring entries,
// one descriptor ram read each. A request is taken only while the engine is
// idle; a result held in the output register does not hold off the next
// request, but its result then keeps the engine busy until the register frees
// reset: pointers, counts and totals clear at once; ram contents stay
// unknown, and no slot's data is used before that slot is written
// ----------------------------------------------------------------------------
module byte_counted_descriptor_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic                           queue_sel,
	input  logic [bcdq_pkg::ADDR_W-1:0]    entry_addr,
	input  logic [bcdq_pkg::FLEN_W-1:0]    entry_len,
	input  logic [bcdq_pkg::AMT_W-1:0]     amount,
	input  logic                           drain_flag,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bcdq_pkg::TOT_W-1:0]     bytes_done,
	output logic                           status,
	output logic [bcdq_pkg::TOT_W-1:0]     queued_unread_out,
	output logic [bcdq_pkg::TOT_W-1:0]     pending_unread_out,
	output logic [bcdq_pkg::DRN_W-1:0]     queued_drained_out,
	output logic [bcdq_pkg::DRN_W-1:0]     pending_drained_out,
	output logic [bcdq_pkg::ADDR_W-1:0]    pending_head_addr,
	output logic [bcdq_pkg::FLEN_W-1:0]    pending_head_len
);
	import bcdq_pkg::*;

	req_t     req;
	ram_req_t q_req, p_req;
	entry_t   q_rdata, p_rdata;
	logic     res_free, res_valid;
	res_t     res, res_q;
	logic     out_valid_q;

	assign req = '{cmd: cmd, queue_sel: queue_sel, entry_addr: entry_addr,
		entry_len: entry_len, amount: amount, drain_flag: drain_flag};

	// descriptor ring of the queued side
	bcdq_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_queued_ram (
		.clk   (clk),
		.we    (q_req.we),
		.waddr (q_req.waddr),
		.wdata (q_req.wdata),
		.re    (q_req.re),
		.raddr (q_req.raddr),
		.rdata (q_rdata)
	);

	// descriptor ring of the pending side
	bcdq_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_pending_ram (
		.clk   (clk),
		.we    (p_req.we),
		.waddr (p_req.waddr),
		.wdata (p_req.wdata),
		.re    (p_req.re),
		.raddr (p_req.raddr),
		.rdata (p_rdata)
	);

	bcdq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req       (req),
		.busy      (in_stall),
		.q_rdata   (q_rdata),
		.p_rdata   (p_rdata),
		.q_req     (q_req),
		.p_req     (p_req),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register, free when empty or being taken
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign bytes_done          = res_q.bytes_done;
	assign status              = res_q.status;
	assign queued_unread_out   = res_q.queued_unread;
	assign pending_unread_out  = res_q.pending_unread;
	assign queued_drained_out  = res_q.queued_drained;
	assign pending_drained_out = res_q.pending_drained;
	assign pending_head_addr   = res_q.head_addr;
	assign pending_head_len    = res_q.head_len;

endmodule
